### rtl/vna_pkg.sv
package vna_pkg;

	localparam int SUM_W   = 48;
	localparam int MUL_W   = 31;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MAG_W   = 30;
	localparam int SQ_W    = PROD_W;
	localparam int ROOT_W  = 32;
	localparam int FRAC_W  = 15;
	localparam int QUO_W   = 17;
	localparam int NRM_W   = 16;
	localparam int IDX_W   = 12;
	localparam int REM_W   = MAG_W + FRAC_W + 1;
	localparam int DVS_W   = ROOT_W + QUO_W - 1;
	localparam int SQRT_STEPS  = SQ_W / 2;
	localparam int CROSS_STEPS = 6;
	localparam int SQ_STEPS    = 3;
	localparam int CNT_W   = 5;

	localparam logic [1:0] MODE_LIST  = 2'd1;
	localparam logic [1:0] MODE_STRIP = 2'd2;
	localparam logic       REG_MODE   = 1'b0;
	localparam logic [1:0] LAST_CORNER = 2'd2;

	typedef enum logic [1:0] {OP_CLEAR, OP_LOAD, OP_TRI, OP_READ} op_t;
	typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C, SEL_V} sel_t;
	typedef enum logic [3:0] {
		ST_XA, ST_XB, ST_YA, ST_YB, ST_ZA, ST_ZB, ST_SQX, ST_SQY, ST_SQZ
	} step_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         vertex;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [9:0]         index_a;
		logic [9:0]         index_b;
		logic [9:0]         index_c;
		logic [9:0]         triangle_number;
	} item_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               status;
	} result_t;

	typedef struct packed {
		logic       capture;
		logic       clr_step;
		logic       pos_wr;
		sel_t       rsel;
		logic       pos_lat;
		sel_t       lsel;
		logic       edge_en;
		logic       mul_en;
		step_t      msel;
		logic       acc_en;
		step_t      asel;
		logic       sum_wr;
		logic       mag_en;
		logic       shift_r;
		logic       shift_l;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       div_init;
		logic       div_step;
		logic       div_fin;
		logic [1:0] csel;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic bad;
		logic sweep_last;
		logic mag_zero;
		logic mag_hi;
		logic mag_lo;
	} stat_t;

endpackage

### rtl/vna_ram.sv
module vna_ram #(
	parameter int W = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/vna_ctrl.sv
module vna_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	output logic          result_valid,
	input  logic          result_ready,
	input  vna_pkg::stat_t stat,
	output vna_pkg::cmd_t  cmd
);
	import vna_pkg::*;

	typedef enum logic [4:0] {
		S_SWEEP, S_IDLE, S_DEC, S_CLR, S_LD,
		S_PRD0, S_PRD1, S_PRD2, S_PLAT, S_EDGE, S_MUL, S_SRD, S_SWR,
		S_RRD, S_RMAG, S_SHIFT, S_SQ, S_SQI, S_SQRT, S_DINIT, S_DIV, S_DFIN,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       idx_q;
	logic             out_v_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_v_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_SWEEP: cmd.clr_step = 1'b1;
			S_IDLE:  cmd.capture = item_valid;
			S_DEC:   cmd.pos_wr = (stat.op == OP_LOAD) && !stat.bad;
			S_CLR:   cmd.clr_step = 1'b1;
			S_PRD0:  cmd.rsel = SEL_A;
			S_PRD1: begin
				cmd.rsel = SEL_B;
				cmd.pos_lat = 1'b1;
				cmd.lsel = SEL_A;
			end
			S_PRD2: begin
				cmd.rsel = SEL_C;
				cmd.pos_lat = 1'b1;
				cmd.lsel = SEL_B;
			end
			S_PLAT: begin
				cmd.pos_lat = 1'b1;
				cmd.lsel = SEL_C;
			end
			S_EDGE:  cmd.edge_en = 1'b1;
			S_MUL: begin
				cmd.mul_en = (cnt_q < CNT_W'(CROSS_STEPS));
				cmd.msel = step_t'(cnt_q[3:0]);
				cmd.acc_en = (cnt_q != '0);
				cmd.asel = step_t'(cnt_q[3:0] - 4'd1);
			end
			S_SRD:   cmd.rsel = sel_t'(idx_q);
			S_SWR: begin
				cmd.rsel = sel_t'(idx_q);
				cmd.sum_wr = 1'b1;
			end
			S_RRD:   cmd.rsel = SEL_V;
			S_RMAG:  cmd.mag_en = 1'b1;
			S_SHIFT: begin
				cmd.shift_r = stat.mag_hi;
				cmd.shift_l = stat.mag_lo;
			end
			S_SQ: begin
				cmd.mul_en = (cnt_q < CNT_W'(SQ_STEPS));
				cmd.msel = step_t'(ST_SQX + cnt_q[3:0]);
				cmd.acc_en = (cnt_q != '0);
				cmd.asel = step_t'(ST_SQX + cnt_q[3:0] - 4'd1);
			end
			S_SQI:   cmd.sqrt_init = 1'b1;
			S_SQRT:  cmd.sqrt_step = 1'b1;
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cmd.csel = idx_q;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_DFIN: begin
				cmd.div_fin = 1'b1;
				cmd.csel = idx_q;
			end
			S_DONE:  cmd.out_load = !out_v_q || result_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			cnt_q   <= '0;
			idx_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_v_q <= 1'b1;
			end else if (result_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: if (stat.sweep_last) state_q <= S_IDLE;
				S_IDLE:  if (item_valid) state_q <= S_DEC;
				S_DEC: begin
					unique case (stat.op)
						OP_CLEAR: state_q <= S_CLR;
						OP_LOAD:  state_q <= S_DONE;
						OP_TRI:   state_q <= stat.bad ? S_DONE : S_PRD0;
						OP_READ:  state_q <= stat.bad ? S_DONE : S_RRD;
					endcase
				end
				S_CLR:  if (stat.sweep_last) state_q <= S_DONE;
				S_PRD0: state_q <= S_PRD1;
				S_PRD1: state_q <= S_PRD2;
				S_PRD2: state_q <= S_PLAT;
				S_PLAT: state_q <= S_EDGE;
				S_EDGE: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(CROSS_STEPS)) begin
						idx_q   <= '0;
						state_q <= S_SRD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (idx_q == LAST_CORNER) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_RRD:  state_q <= S_RMAG;
				S_RMAG: state_q <= S_SHIFT;
				S_SHIFT: begin
					if (stat.mag_zero) begin
						state_q <= S_DONE;
					end else if (!stat.mag_hi && !stat.mag_lo) begin
						cnt_q   <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == CNT_W'(SQ_STEPS)) begin
						state_q <= S_SQI;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQI: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
						idx_q   <= '0;
						state_q <= S_DINIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DINIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(QUO_W - 1)) begin
						state_q <= S_DFIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DFIN: begin
					if (idx_q == LAST_CORNER) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_DINIT;
					end
				end
				S_DONE: if (cmd.out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/vna_dp.sv
module vna_dp #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       mode,
	input  vna_pkg::item_t   item,
	input  vna_pkg::cmd_t    cmd,
	output vna_pkg::stat_t   stat,
	output vna_pkg::result_t result
);
	import vna_pkg::*;

	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int CB   = COORD_BITS;
	localparam int PW   = 3 * CB;
	localparam int EW   = CB + 1;
	localparam int NW   = 2 * EW + 1;
	localparam int ADDW = ((NW > SUM_W) ? NW : SUM_W) + 1;
	localparam logic signed [ADDW-1:0] LIM_HI = ADDW'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [ADDW-1:0] LIM_LO = ~LIM_HI;
	localparam logic [QUO_W-1:0] Q_SAT = QUO_W'(2**(NRM_W-1) - 1);

	logic [IDX_W-1:0] t, o, ia, ib, ic;
	logic             tri_bad, v_bad;

	op_t              op_q;
	logic             bad_q;
	logic [AW-1:0]    vaddr_q, sweep_q, raddr;
	logic [AW-1:0]    caddr_q [3];
	logic [PW-1:0]    pos_q, pos_rd;
	logic [3*SUM_W-1:0] sum_rd, sum_new;

	logic signed [CB-1:0]     crd_q [3][3];
	logic signed [EW-1:0]     e1_q [3];
	logic signed [EW-1:0]     e2_q [3];
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [NW-1:0]     nrm_q [3];
	logic signed [ADDW-1:0]   add_s [3];
	logic [SUM_W-1:0]         m_q [3];
	logic                     neg_q [3];
	logic [SUM_W-1:0]         mx;
	logic [SQ_W-1:0]          ss_q, v_q, r_q, bit_q;
	logic [SQ_W:0]            sq_t;
	logic [ROOT_W-1:0]        root;
	logic [REM_W-1:0]         rem_q;
	logic [DVS_W-1:0]         d_q;
	logic [QUO_W-1:0]         q_q;
	logic [NRM_W-1:0]         qsat;
	logic signed [NRM_W-1:0]  res_q [3];
	result_t                  out_q;

	always_comb begin
		t = IDX_W'(item.triangle_number);
		o = IDX_W'(t[0]);
		unique case (mode)
			MODE_LIST: begin
				ia = (t << 1) + t;
				ib = ia + IDX_W'(1);
				ic = ia + IDX_W'(2);
			end
			MODE_STRIP: begin
				ia = t + o;
				ib = t + IDX_W'(1) + o;
				ic = t + IDX_W'(2) - o;
			end
			default: begin
				ia = IDX_W'(item.index_a);
				ib = IDX_W'(item.index_b);
				ic = IDX_W'(item.index_c);
			end
		endcase
		tri_bad = (32'(ia) >= MAX_VERTICES) || (32'(ib) >= MAX_VERTICES)
			|| (32'(ic) >= MAX_VERTICES);
		v_bad = (32'(item.vertex) >= MAX_VERTICES);
	end

	always_comb begin
		unique case (cmd.rsel)
			SEL_A: raddr = caddr_q[0];
			SEL_B: raddr = caddr_q[1];
			SEL_C: raddr = caddr_q[2];
			SEL_V: raddr = vaddr_q;
		endcase
	end

	vna_ram #(.W(PW), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (cmd.pos_wr),
		.waddr (vaddr_q),
		.wdata (pos_q),
		.raddr (raddr),
		.rdata (pos_rd)
	);

	vna_ram #(.W(3*SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (cmd.clr_step || cmd.sum_wr),
		.waddr (cmd.clr_step ? sweep_q : raddr),
		.wdata (cmd.clr_step ? '0 : sum_new),
		.raddr (raddr),
		.rdata (sum_rd)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			add_s[k] = ADDW'(signed'(sum_rd[SUM_W*(3-k)-1 -: SUM_W])) + ADDW'(nrm_q[k]);
			if (add_s[k] > LIM_HI) begin
				sum_new[SUM_W*(3-k)-1 -: SUM_W] = SUM_W'(LIM_HI);
			end else if (add_s[k] < LIM_LO) begin
				sum_new[SUM_W*(3-k)-1 -: SUM_W] = SUM_W'(LIM_LO);
			end else begin
				sum_new[SUM_W*(3-k)-1 -: SUM_W] = SUM_W'(add_s[k]);
			end
		end
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.msel)
			ST_XA: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[2]); end
			ST_XB: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[1]); end
			ST_YA: begin mul_a = MUL_W'(e1_q[2]); mul_b = MUL_W'(e2_q[0]); end
			ST_YB: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[2]); end
			ST_ZA: begin mul_a = MUL_W'(e1_q[0]); mul_b = MUL_W'(e2_q[1]); end
			ST_ZB: begin mul_a = MUL_W'(e1_q[1]); mul_b = MUL_W'(e2_q[0]); end
			ST_SQX: begin
				mul_a = signed'(MUL_W'(m_q[0][MAG_W-1:0]));
				mul_b = mul_a;
			end
			ST_SQY: begin
				mul_a = signed'(MUL_W'(m_q[1][MAG_W-1:0]));
				mul_b = mul_a;
			end
			ST_SQZ: begin
				mul_a = signed'(MUL_W'(m_q[2][MAG_W-1:0]));
				mul_b = mul_a;
			end
			default: ;
		endcase
	end

	assign mx   = m_q[0] | m_q[1] | m_q[2];
	assign sq_t = {1'b0, r_q} + {1'b0, bit_q};
	assign root = r_q[ROOT_W-1:0];
	assign qsat = (q_q > Q_SAT) ? NRM_W'(Q_SAT) : NRM_W'(q_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.clr_step) begin
			sweep_q <= (sweep_q == AW'(MAX_VERTICES - 1)) ? '0 : sweep_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q       <= item.op;
			vaddr_q    <= AW'(item.vertex);
			pos_q      <= {CB'(item.pos_x), CB'(item.pos_y), CB'(item.pos_z)};
			caddr_q[0] <= AW'(ia);
			caddr_q[1] <= AW'(ib);
			caddr_q[2] <= AW'(ic);
			unique case (item.op)
				OP_TRI:           bad_q <= tri_bad;
				OP_LOAD, OP_READ: bad_q <= v_bad;
				default:          bad_q <= 1'b0;
			endcase
			for (int k = 0; k < 3; k++) begin
				res_q[k] <= '0;
			end
		end
		if (cmd.pos_lat) begin
			for (int k = 0; k < 3; k++) begin
				unique case (cmd.lsel)
					SEL_A:   crd_q[0][k] <= pos_rd[PW-1-k*CB -: CB];
					SEL_B:   crd_q[1][k] <= pos_rd[PW-1-k*CB -: CB];
					SEL_C:   crd_q[2][k] <= pos_rd[PW-1-k*CB -: CB];
					default: ;
				endcase
			end
		end
		if (cmd.edge_en) begin
			for (int k = 0; k < 3; k++) begin
				e1_q[k] <= EW'(crd_q[1][k]) - EW'(crd_q[0][k]);
				e2_q[k] <= EW'(crd_q[2][k]) - EW'(crd_q[0][k]);
			end
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.acc_en) begin
			unique case (cmd.asel)
				ST_XA:  nrm_q[0] <= NW'(prod_q);
				ST_XB:  nrm_q[0] <= nrm_q[0] - NW'(prod_q);
				ST_YA:  nrm_q[1] <= NW'(prod_q);
				ST_YB:  nrm_q[1] <= nrm_q[1] - NW'(prod_q);
				ST_ZA:  nrm_q[2] <= NW'(prod_q);
				ST_ZB:  nrm_q[2] <= nrm_q[2] - NW'(prod_q);
				ST_SQX: ss_q <= unsigned'(prod_q);
				ST_SQY, ST_SQZ: ss_q <= ss_q + unsigned'(prod_q);
				default: ;
			endcase
		end
		if (cmd.mag_en) begin
			for (int k = 0; k < 3; k++) begin
				neg_q[k] <= sum_rd[SUM_W*(3-k)-1];
				m_q[k]   <= sum_rd[SUM_W*(3-k)-1] ? -sum_rd[SUM_W*(3-k)-1 -: SUM_W]
					: sum_rd[SUM_W*(3-k)-1 -: SUM_W];
			end
		end else if (cmd.shift_r) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] >> 1;
			end
		end else if (cmd.shift_l) begin
			for (int k = 0; k < 3; k++) begin
				m_q[k] <= m_q[k] << 1;
			end
		end
		if (cmd.sqrt_init) begin
			v_q   <= ss_q;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (cmd.sqrt_step) begin
			if ({1'b0, v_q} >= sq_t) begin
				v_q <= v_q - sq_t[SQ_W-1:0];
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.div_init) begin
			rem_q <= REM_W'({m_q[cmd.csel][MAG_W-1:0], {FRAC_W{1'b0}}})
				+ REM_W'(root[ROOT_W-1:1]);
			d_q   <= {root, {(QUO_W-1){1'b0}}};
			q_q   <= '0;
		end else if (cmd.div_step) begin
			if (DVS_W'(rem_q) >= d_q) begin
				rem_q <= rem_q - d_q[REM_W-1:0];
				q_q   <= {q_q[QUO_W-2:0], 1'b1};
			end else begin
				q_q   <= {q_q[QUO_W-2:0], 1'b0};
			end
			d_q <= d_q >> 1;
		end
		if (cmd.div_fin) begin
			res_q[cmd.csel] <= neg_q[cmd.csel] ? -signed'(qsat) : signed'(qsat);
		end
		if (cmd.out_load) begin
			out_q.normal_x <= res_q[0];
			out_q.normal_y <= res_q[1];
			out_q.normal_z <= res_q[2];
			out_q.status   <= bad_q;
		end
	end

	assign stat.op         = op_q;
	assign stat.bad        = bad_q;
	assign stat.sweep_last = (sweep_q == AW'(MAX_VERTICES - 1));
	assign stat.mag_zero   = (mx == '0);
	assign stat.mag_hi     = |mx[SUM_W-1:MAG_W];
	assign stat.mag_lo     = !(|mx[SUM_W-1:MAG_W]) && !mx[MAG_W-1];
	assign result          = out_q;

endmodule

### rtl/vertex_normal_accumulator_top.sv
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_ready     item   (vna_pkg::item_t)
// result    out        result_valid / result_ready result (vna_pkg::result_t)
// config    in         psel penable pwrite pready  paddr pwdata prdata
//
// One item at a time; a new request is taken while the previous result waits.
// Load and an out-of-range triangle or read skip straight to the result. Triangle:
// three position reads, one shared multiplier for six products, read-modify-write
// of three sums. Read: a zero sum skips the arithmetic, else up to 29 normalizing
// shifts, a 31-step square root and three 17-step divides. Clear: all sums zeroed.
// After reset a clearing pass over all MAX_VERTICES sums runs before item_ready.
module vertex_normal_accumulator_top #(
	parameter int MAX_VERTICES = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             item_valid,
	output logic             item_ready,
	input  vna_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output vna_pkg::result_t result
);
	import vna_pkg::*;

	logic [1:0] mode_q;
	cmd_t       cmd;
	stat_t      stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MODE) ? {30'b0, mode_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
			mode_q <= pwdata[1:0];
		end
	end

	vna_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	vna_dp #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("request accepted while busy");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid || result_ready))
		else $error("result overwritten before taken");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !item_ready)
		else $error("request taken during clearing pass");

endmodule

### tb/sv/vertex_normal_accumulator_top_test.sv
module vertex_normal_accumulator_top_test;
	import vna_pkg::*;

	localparam int NV = 1024;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 205;

	typedef struct {
		logic [1:0] mode;
		item_t      it;
		bit         known;
		result_t    res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;

	vertex_normal_accumulator_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	logic signed [15:0] pos_x_mem[NV];
	logic signed [15:0] pos_y_mem[NV];
	logic signed [15:0] pos_z_mem[NV];
	bit                 pos_loaded[NV];
	int                 loaded_list[$];
	longint             acc_x[NV];
	longint             acc_y[NV];
	longint             acc_z[NV];
	logic [1:0]         mode_reg;

	result_t pending_normals[$];
	row_t    rows[$];
	int      errors;
	int      cycles;
	int      sent;
	int      seen;
	int      op_count[4];
	int      hold_left;
	bit      hold_done;
	bit      calm;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void corners(input logic [1:0] m, input item_t it,
		output int a, output int b, output int c);
		int t;
		int o;
		t = int'(it.triangle_number);
		o = t & 1;
		if (m == MODE_LIST) begin
			a = 3 * t;
			b = a + 1;
			c = a + 2;
		end else if (m == MODE_STRIP) begin
			a = t + o;
			b = t + 1 + o;
			c = t + 2 - o;
		end else begin
			a = int'(it.index_a);
			b = int'(it.index_b);
			c = int'(it.index_c);
		end
	endfunction

	function automatic longint clamp47(longint s, longint d);
		longint r;
		r = s + d;
		if (r > 64'sh7FFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF;
		if (r < -64'sh8000_0000_0000) r = -64'sh8000_0000_0000;
		return r;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic result_t unit_normal(int v);
		longint          s[3];
		longint unsigned m[3];
		longint unsigned mx;
		longint unsigned n;
		longint unsigned q;
		logic [15:0]     w[3];
		int              len;
		result_t         r;
		s[0] = acc_x[v];
		s[1] = acc_y[v];
		s[2] = acc_z[v];
		for (int i = 0; i < 3; i++) m[i] = (s[i] < 0) ? -s[i] : s[i];
		mx = m[0] | m[1] | m[2];
		r = '0;
		if (mx == 0) return r;
		len = 0;
		while ((mx >> len) != 0) len++;
		for (int i = 0; i < 3; i++) begin
			if (len > 30) m[i] = m[i] >> (len - 30);
			else m[i] = m[i] << (30 - len);
		end
		n = root64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 32768 + n / 2) / n;
			if (q > 32767) q = 32767;
			if (s[i] < 0) q = -q;
			w[i] = q[15:0];
		end
		r.normal_x = w[0];
		r.normal_y = w[1];
		r.normal_z = w[2];
		return r;
	endfunction

	function automatic result_t apply_item(item_t it);
		result_t r;
		int      a;
		int      b;
		int      c;
		int      idx[3];
		longint  e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
		r = '0;
		op_count[it.op]++;
		case (it.op)
			OP_CLEAR: begin
				for (int i = 0; i < NV; i++) begin
					acc_x[i] = 0;
					acc_y[i] = 0;
					acc_z[i] = 0;
				end
			end
			OP_LOAD: begin
				pos_x_mem[it.vertex] = it.pos_x;
				pos_y_mem[it.vertex] = it.pos_y;
				pos_z_mem[it.vertex] = it.pos_z;
				if (!pos_loaded[it.vertex]) loaded_list.push_back(int'(it.vertex));
				pos_loaded[it.vertex] = 1'b1;
			end
			OP_TRI: begin
				corners(mode_reg, it, a, b, c);
				if (a >= NV || b >= NV || c >= NV) begin
					r.status = 1'b1;
				end else begin
					e1x = longint'(pos_x_mem[b]) - pos_x_mem[a];
					e1y = longint'(pos_y_mem[b]) - pos_y_mem[a];
					e1z = longint'(pos_z_mem[b]) - pos_z_mem[a];
					e2x = longint'(pos_x_mem[c]) - pos_x_mem[a];
					e2y = longint'(pos_y_mem[c]) - pos_y_mem[a];
					e2z = longint'(pos_z_mem[c]) - pos_z_mem[a];
					nx = e1y * e2z - e1z * e2y;
					ny = e1z * e2x - e1x * e2z;
					nz = e1x * e2y - e1y * e2x;
					idx[0] = a;
					idx[1] = b;
					idx[2] = c;
					for (int i = 0; i < 3; i++) begin
						acc_x[idx[i]] = clamp47(acc_x[idx[i]], nx);
						acc_y[idx[i]] = clamp47(acc_y[idx[i]], ny);
						acc_z[idx[i]] = clamp47(acc_z[idx[i]], nz);
					end
				end
			end
			default: r = unit_normal(int'(it.vertex));
		endcase
		return r;
	endfunction

	function automatic item_t mk(op_t op, int v, int x, int y, int z, int a, int b, int c,
		int t);
		item_t it;
		it.op = op;
		it.vertex = 10'(v);
		it.pos_x = 16'(x);
		it.pos_y = 16'(y);
		it.pos_z = 16'(z);
		it.index_a = 10'(a);
		it.index_b = 10'(b);
		it.index_c = 10'(c);
		it.triangle_number = 10'(t);
		return it;
	endfunction

	function automatic item_t random_item(logic [1:0] m);
		item_t        it;
		logic [127:0] raw;
		int           r;
		int           a;
		int           b;
		int           c;
		raw = {$urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(item_t)-1:0];
		r = $urandom_range(0, 99);
		if (r < 2) it.op = OP_CLEAR;
		else if (r < 37) it.op = OP_LOAD;
		else if (r < 72) it.op = OP_TRI;
		else it.op = OP_READ;
		if (it.op == OP_LOAD && $urandom_range(0, 99) < 70)
			it.vertex = 10'($urandom_range(0, 63));
		if (it.op == OP_TRI) begin
			if (m == MODE_LIST) begin
				it.triangle_number = ($urandom_range(0, 99) < 85) ?
					10'($urandom_range(0, 20)) : 10'($urandom_range(342, 1023));
			end else if (m == MODE_STRIP) begin
				it.triangle_number = ($urandom_range(0, 99) < 85) ?
					10'($urandom_range(0, 61)) : 10'($urandom_range(1022, 1023));
			end else if (loaded_list.size() == 0) begin
				it.op = OP_LOAD;
			end else begin
				it.index_a = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
				it.index_b = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
				it.index_c = 10'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
				if ($urandom_range(0, 9) == 0) it.index_b = it.index_a;
			end
		end
		if (it.op == OP_TRI) begin
			corners(m, it, a, b, c);
			if (a < NV && b < NV && c < NV) begin
				if (!pos_loaded[a]) begin
					it.op = OP_LOAD;
					it.vertex = 10'(a);
				end else if (!pos_loaded[b]) begin
					it.op = OP_LOAD;
					it.vertex = 10'(b);
				end else if (!pos_loaded[c]) begin
					it.op = OP_LOAD;
					it.vertex = 10'(c);
				end
			end
		end
		return it;
	endfunction

	task automatic send_request(item_t it, bit known, result_t res);
		result_t r;
		while (!calm && $urandom_range(0, 99) < 29) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		r = apply_item(it);
		pending_normals.push_back(known ? res : r);
		sent++;
		calm = (sent >= 700 && sent < 900);
	endtask

	task automatic set_mode(logic [1:0] m);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'd4 * REG_MODE;
		pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mode_reg = m;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			seen++;
			if (pending_normals.size() == 0) begin
				$error("result with nothing pending: %h", result);
				errors++;
			end else begin
				result_t e;
				e = pending_normals.pop_front();
				if (result.normal_x !== e.normal_x) begin
					$error("normal_x expected %0d got %0d", e.normal_x, result.normal_x);
					errors++;
				end
				if (result.normal_y !== e.normal_y) begin
					$error("normal_y expected %0d got %0d", e.normal_y, result.normal_y);
					errors++;
				end
				if (result.normal_z !== e.normal_z) begin
					$error("normal_z expected %0d got %0d", e.normal_z, result.normal_z);
					errors++;
				end
				if (result.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, result.status);
					errors++;
				end
			end
		end
	end

	initial begin
		result_ready = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (!hold_done && seen >= 300) begin
				hold_done = 1'b1;
				hold_left = 400;
				result_ready <= 1'b0;
			end else begin
				result_ready <= calm || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	initial begin
		logic [1:0] phase_modes[8];
		result_t    z;
		result_t    bad;
		int         waited;
		phase_modes = '{2'd0, MODE_LIST, MODE_STRIP, 2'd3, MODE_LIST, 2'd0, MODE_STRIP, 2'd0};
		z = '0;
		bad = '0;
		bad.status = 1'b1;
		errors = 0;
		cycles = 0;
		sent = 0;
		seen = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		mode_reg = 2'd0;
		for (int i = 0; i < NV; i++) begin
			pos_loaded[i] = 1'b0;
			acc_x[i] = 0;
			acc_y[i] = 0;
			acc_z[i] = 0;
		end
		for (int i = 0; i < 4; i++) op_count[i] = 0;

		rows.push_back('{2'd0, mk(OP_READ, 5, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_LOAD, 0, -32768, -32768, -32768, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_LOAD, 1, 32767, -32768, 0, 1023, 1023, 1023, 1023),
			1'b1, z});
		rows.push_back('{2'd0, mk(OP_LOAD, 2, 0, 32767, 32767, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_LOAD, 1023, 32767, 32767, 32767, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_TRI, 0, 0, 0, 0, 0, 1, 2, 1023), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{2'd0, mk(OP_READ, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{2'd0, mk(OP_TRI, 0, 0, 0, 0, 0, 0, 1, 0), 1'b1, z});
		rows.push_back('{2'd0, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{2'd3, mk(OP_TRI, 0, 0, 0, 0, 1023, 1023, 1023, 0), 1'b1, z});
		rows.push_back('{2'd3, mk(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{MODE_LIST, mk(OP_TRI, 0, 0, 0, 0, 0, 0, 0, 1023), 1'b1, bad});
		rows.push_back('{MODE_LIST, mk(OP_TRI, 0, 0, 0, 0, 1023, 1023, 1023, 0), 1'b1, z});
		rows.push_back('{MODE_LIST, mk(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{MODE_STRIP, mk(OP_TRI, 0, 0, 0, 0, 0, 0, 0, 1022), 1'b1, bad});
		rows.push_back('{MODE_STRIP, mk(OP_LOAD, 3, 100, -200, 300, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{MODE_STRIP, mk(OP_TRI, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, z});
		rows.push_back('{MODE_STRIP, mk(OP_READ, 2, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{MODE_STRIP, mk(OP_READ, 3, 0, 0, 0, 0, 0, 0, 0), 1'b0, z});
		rows.push_back('{MODE_STRIP, mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
		rows.push_back('{MODE_STRIP, mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].mode != mode_reg) set_mode(rows[i].mode);
			send_request(rows[i].it, rows[i].known, rows[i].res);
		end

		foreach (phase_modes[p]) begin
			set_mode(phase_modes[p]);
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_request(random_item(mode_reg), 1'b0, z);
		end

		item_valid <= 1'b0;
		waited = 0;
		while (pending_normals.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (200) @(posedge clk);
		if (pending_normals.size() != 0) begin
			$error("%0d results never arrived", pending_normals.size());
			errors++;
		end
		$display("covered %0d requests: %0d clear, %0d load, %0d triangle, %0d read",
			sent, op_count[OP_CLEAR], op_count[OP_LOAD], op_count[OP_TRI], op_count[OP_READ]);
		$display("modes indexed, list, strip and reserved; %0d results checked", seen);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

### files.f
rtl/vna_pkg.sv
rtl/vna_ram.sv
rtl/vna_ctrl.sv
rtl/vna_dp.sv
rtl/vertex_normal_accumulator_top.sv
tb/sv/vertex_normal_accumulator_top_test.sv
